FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the top-level writer module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication check, ignored while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lcdnw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcdnw_pkg;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_TEXT  = 2'd0,
    OP_CMD   = 2'd1,
    OP_GOTO  = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROW0_BASE     = 3'd0;
  localparam logic [2:0] REG_ROW1_BASE     = 3'd1;
  localparam logic [2:0] REG_LINE_LENGTH   = 3'd2;
  localparam logic [2:0] REG_FUNCTION_WORD = 3'd3;
  localparam logic [2:0] REG_DISPLAY_WORD  = 3'd4;
  localparam logic [2:0] REG_ENTRY_WORD    = 3'd5;

  // Fixed LCD commands.
  localparam logic [7:0] CMD_HOME4 = 8'h02;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  // Widths.
  localparam int COUNT_W = 7;
  localparam int LEN_W   = 6;
  localparam int COL_W   = 6;
  localparam int IDX_W   = 3;

  // Job queue geometry.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Live configuration.
  typedef struct packed {
    logic [7:0]       row0_base;
    logic [7:0]       row1_base;
    logic [LEN_W-1:0] line_length;
    logic [7:0]       function_word;
    logic [7:0]       display_word;
    logic [7:0]       entry_word;
  } cfg_t;

  // Byte sequence kinds that the back end plays out.
  typedef enum logic [1:0] {
    JOB_SINGLE    = 2'd0,
    JOB_TEXT_ROW1 = 2'd1,
    JOB_TEXT_WRAP = 2'd2,
    JOB_INIT      = 2'd3
  } job_kind_t;

  // One classified item.
  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] data;
  } job_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/char_lcd_nibble_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Beat contents
// in_     | slave     | tuser = op; tdata = value, start_of_text, row, col
// out_    | master    | tuser = reg_sel; tdata = nibble; tlast = last of item
// cfg_    | write     | cfg_addr selects one of six registers, cfg_wdata value
//
// The back end sends one nibble per cycle while the output is not stalled: an item is
// 2, 4, 6 or 12 nibbles, set by its byte count in the nibble sequencer.
// The front end classifies one input beat per cycle while the two-entry job
// queue has room, so input is taken while results are still going out.
// Reset is synchronous: configuration returns to defaults, count and queue clear.
// A stalled output holds its beat; the sequencer and queue wait behind it.

`include "assert_macros.svh"

module char_lcd_nibble_writer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] value, [8] start_of_text, [9] row, [15:10] col
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [7:0]  out_tdata,  // [3:0] nibble, [7:4] zero
  output      logic        out_tuser,  // [0] reg_sel
  output      logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);
  import lcdnw_pkg::*;

  cfg_t        cfg_r;
  job_t        front_job;
  job_t        head_job;
  queue_stat_t q_stat;
  logic        in_accept;
  logic        q_pop;
  logic [3:0]  out_nibble;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row0_base     <= 8'h80;
      cfg_r.row1_base     <= 8'hC0;
      cfg_r.line_length   <= LEN_W'(16);
      cfg_r.function_word <= 8'h28;
      cfg_r.display_word  <= 8'h0F;
      cfg_r.entry_word    <= 8'h06;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW0_BASE:     cfg_r.row0_base     <= cfg_wdata;
        REG_ROW1_BASE:     cfg_r.row1_base     <= cfg_wdata;
        REG_LINE_LENGTH:   cfg_r.line_length   <= cfg_wdata[LEN_W-1:0];
        REG_FUNCTION_WORD: cfg_r.function_word <= cfg_wdata;
        REG_DISPLAY_WORD:  cfg_r.display_word  <= cfg_wdata;
        REG_ENTRY_WORD:    cfg_r.entry_word    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_stat.full;
  assign in_accept = in_tvalid && in_tready;

  lcdnw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (in_accept),
    .op            (in_tuser),
    .value         (in_tdata[7:0]),
    .start_of_text (in_tdata[8]),
    .row           (in_tdata[9]),
    .col           (in_tdata[15:10]),
    .job           (front_job)
  );

  lcdnw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_job (front_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  lcdnw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job        (head_job),
    .stat       (q_stat),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_rs     (out_tuser),
    .out_nibble (out_nibble),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'b0000, out_nibble};

  // Queue status is never full and empty at once.
  `ASSERT_CLK(a_queue_stat, clk, rst_n, !(q_stat.full && q_stat.empty), "queue full and empty")
  // A pushed job is visible to the back end in the next cycle.
  `ASSERT_IMPLY(a_push_seen, clk, rst_n, in_accept, !q_stat.empty, "pushed job missing")
  // Retiring a job always puts its final nibble on the output.
  `ASSERT_IMPLY(a_pop_last, clk, rst_n, q_pop, out_tvalid && out_tlast, "pop without last")

endmodule

`default_nettype wire

FILE: hw/rtl/lcdnw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lcdnw_pkg::cfg_t    cfg,
  input  wire logic               accept,
  input  wire logic [1:0]         op,
  input  wire logic [7:0]         value,
  input  wire logic               start_of_text,
  input  wire logic               row,
  input  wire logic [5:0]         col,
  output      lcdnw_pkg::job_t    job
);
  import lcdnw_pkg::*;

  logic [COUNT_W-1:0] char_count_r;
  logic [COUNT_W-1:0] char_count_nxt;
  logic [COUNT_W-1:0] count_base;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] full_count;
  logic [7:0]         goto_addr;

  // Running text count: optional restart, then one more character.
  assign count_base = start_of_text ? '0 : char_count_r;
  assign count_inc  = count_base + COUNT_W'(1);
  assign full_count = {cfg.line_length, 1'b0};
  assign goto_addr  = (row ? cfg.row1_base : cfg.row0_base) + {2'b00, col};

  // Classify the item into a byte sequence and update the count.
  always_comb begin
    char_count_nxt = char_count_r;
    job.kind       = JOB_SINGLE;
    job.rs         = 1'b0;
    job.data       = value;
    unique case (op_t'(op))
      OP_TEXT: begin
        job.rs = 1'b1;
        if (count_inc == {1'b0, cfg.line_length}) begin
          job.kind       = JOB_TEXT_ROW1;
          char_count_nxt = count_inc;
        end else if (count_inc == full_count) begin
          job.kind       = JOB_TEXT_WRAP;
          char_count_nxt = '0;
        end else begin
          job.kind       = JOB_SINGLE;
          char_count_nxt = count_inc;
        end
      end
      OP_CMD: begin
        job.kind = JOB_SINGLE;
      end
      OP_GOTO: begin
        job.kind = JOB_SINGLE;
        job.data = goto_addr;
      end
      OP_INIT: begin
        job.kind = JOB_INIT;
      end
      default: begin
        job.kind = JOB_SINGLE;
      end
    endcase
  end

  // The count moves only on accepted items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r <= '0;
    end else if (accept) begin
      char_count_r <= char_count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdnw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire lcdnw_pkg::job_t       push_job,
  input  wire logic                  pop,
  output      lcdnw_pkg::job_t       head_job,
  output      lcdnw_pkg::queue_stat_t stat
);
  import lcdnw_pkg::*;

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_job   = entry_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdnw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lcdnw_pkg::cfg_t        cfg,
  input  wire lcdnw_pkg::job_t        job,
  input  wire lcdnw_pkg::queue_stat_t stat,
  output      logic                   pop,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic                   out_rs,
  output      logic [3:0]             out_nibble,
  output      logic                   out_last
);
  import lcdnw_pkg::*;

  logic             valid_r;
  logic             rs_r;
  logic [3:0]       nibble_r;
  logic             last_r;
  logic [IDX_W-1:0] idx_r;
  logic             phase_r;

  logic             load;
  logic [IDX_W-1:0] last_idx;
  logic [7:0]       cur_byte;
  logic             cur_rs;
  logic             job_done;

  // Final byte index of each kind.
  always_comb begin
    unique case (job.kind)
      JOB_SINGLE:    last_idx = IDX_W'(0);
      JOB_TEXT_ROW1: last_idx = IDX_W'(1);
      JOB_TEXT_WRAP: last_idx = IDX_W'(2);
      JOB_INIT:      last_idx = IDX_W'(5);
      default:       last_idx = IDX_W'(0);
    endcase
  end

  // Byte and register select for the current step.
  always_comb begin
    cur_byte = job.data;
    cur_rs   = 1'b0;
    if (job.kind == JOB_INIT) begin
      unique case (idx_r)
        IDX_W'(0): cur_byte = CMD_HOME4;
        IDX_W'(1): cur_byte = cfg.function_word;
        IDX_W'(2): cur_byte = cfg.display_word;
        IDX_W'(3): cur_byte = CMD_CLEAR;
        IDX_W'(4): cur_byte = cfg.entry_word;
        default:   cur_byte = cfg.row0_base;
      endcase
    end else if (idx_r == '0) begin
      cur_byte = job.data;
      cur_rs   = job.rs;
    end else if (job.kind == JOB_TEXT_ROW1) begin
      cur_byte = cfg.row1_base;
    end else if (idx_r == IDX_W'(1)) begin
      cur_byte = CMD_CLEAR;
    end else begin
      cur_byte = cfg.row0_base;
    end
  end

  // One nibble enters the output register whenever it is free or drains and the queue holds a job.
  assign load     = !valid_r || out_ready;
  assign job_done = phase_r && (idx_r == last_idx);
  assign pop      = load && !stat.empty && job_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      phase_r <= 1'b0;
    end else if (load) begin
      valid_r <= !stat.empty;
      if (!stat.empty) begin
        if (job_done) begin
          idx_r   <= '0;
          phase_r <= 1'b0;
        end else begin
          phase_r <= !phase_r;
          if (phase_r) begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
      end
    end
  end

  // Output payload, high nibble first.
  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      rs_r     <= cur_rs;
      nibble_r <= phase_r ? cur_byte[3:0] : cur_byte[7:4];
      last_r   <= job_done;
    end
  end

  assign out_valid  = valid_r;
  assign out_rs     = rs_r;
  assign out_nibble = nibble_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire
